@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define MTP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define MTP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/mtp_pkg.sv @@
// shared types, codes and widths for the motor thrust profile block
// no dependencies
package mtp_pkg;

   localparam int MAX_POINTS_DEF = 8;

   localparam int VAL_W      = 32;
   localparam int DT_W       = 16;
   localparam int CMD_W      = 2;
   localparam int PIDX_W     = 3;
   localparam int PCOUNT_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // request commands
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURN_DURATION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT_THRUST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT     = 2'd3;

   localparam logic MODE_CONSTANT = 1'b0;
   localparam logic MODE_PROFILE  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_ENDRD,
      S_TICK,
      S_SEL,
      S_SRCH,
      S_CMP,
      S_PREP,
      S_DIV,
      S_DONE
   } mtp_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_STEP,
      DV_DONE
   } mtp_div_state_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] mul_a;
      logic [VAL_W-1:0] mul_b;
      logic [VAL_W-1:0] divisor;
   } mtp_div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] quotient;
   } mtp_div_rsp_type;

endpackage

@@ hdl/mtp_if.sv @@
// request and response channel interfaces of the motor thrust profile block
// depends on mtp_pkg
interface mtp_req_if;
   import mtp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DT_W-1:0]   delta_time;
   logic [PIDX_W-1:0] point_index;
   logic [VAL_W-1:0]  point_time;
   logic [VAL_W-1:0]  point_thrust;

   modport source (
      output valid, cmd, delta_time, point_index, point_time, point_thrust,
      input  ready
   );
   modport sink (
      input  valid, cmd, delta_time, point_index, point_time, point_thrust,
      output ready
   );
endinterface

interface mtp_rsp_if;
   import mtp_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] thrust_out;
   logic             is_burning;
   logic [VAL_W-1:0] elapsed_burn;

   modport source (
      output valid, thrust_out, is_burning, elapsed_burn,
      input  ready
   );
   modport sink (
      input  valid, thrust_out, is_burning, elapsed_burn,
      output ready
   );
endinterface

@@ hdl/motor_thrust_profile.sv @@
// Motor thrust profile: burn time and thrust of a rocket motor advanced by ticks.
// Requests come in on req_ch: a time tick, a breakpoint write or a burn restart.
// Every request gives exactly one response on rsp_ch with the thrust, the burning
// flag and the burn time after that request. Mode, burn duration, constant thrust
// and breakpoint count are written on the csr_ port, by the user only while no
// request is in flight; the block itself does not enforce it. One request is
// handled at a time; req_ch.ready is high only while idle. After acceptance a
// request runs through EXEC, ENDRD, TICK and SEL; SEL goes to DONE when the
// thrust needs no interpolation (constant mode, exhausted, past the profile end,
// no points). Otherwise SRCH and CMP scan the breakpoint memory one point at a
// time (1 to MAX_POINTS points); a zero-length segment ends in PREP, else PREP
// starts the multiply/divide unit, which forms the product and runs 32 quotient steps.
// A new request can be taken in the cycle after the response is accepted.
// If the receiver stalls, the response holds and no new request is taken.
// Reset (synchronous, active high) clears the state and csr registers, sets the
// motor burning with zero burn time; datapath and breakpoint memory are not cleared.
module motor_thrust_profile #(
   parameter int MAX_POINTS = mtp_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   mtp_req_if.sink                          req_ch,
   mtp_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [mtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mtp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mtp_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // control and configuration
   mtp_state_type        state_ff, state_in;
   logic                 motor_mode_ff;
   logic [VAL_W-1:0]     burn_duration_ff;
   logic [VAL_W-1:0]     constant_thrust_ff;
   logic [PCOUNT_W-1:0]  point_count_ff;
   logic                 burning_ff, burning_in;
   logic [VAL_W-1:0]     burn_time_ff, burn_time_in;

   // request fields and working values
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [DT_W-1:0]      dt_ff, dt_in;
   logic [PIDX_W-1:0]    pidx_ff, pidx_in;
   logic [VAL_W-1:0]     ptime_ff, ptime_in;
   logic [VAL_W-1:0]     pthrust_ff, pthrust_in;
   logic [VAL_W-1:0]     end_ff, end_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [VAL_W-1:0]     s_time_ff, s_time_in;
   logic [VAL_W-1:0]     s_thrust_ff, s_thrust_in;
   logic [VAL_W-1:0]     e_thrust_ff, e_thrust_in;
   logic [VAL_W-1:0]     elapsed_ff, elapsed_in;
   logic [VAL_W-1:0]     len_ff, len_in;
   logic [VAL_W-1:0]     mag_ff, mag_in;
   logic                 up_ff, up_in;
   logic [VAL_W-1:0]     thrust_ff, thrust_in;

   // breakpoint memory
   logic [VAL_W-1:0]     bp_time_mem   [MAX_POINTS];
   logic [VAL_W-1:0]     bp_thrust_mem [MAX_POINTS];
   logic [VAL_W-1:0]     rd_time_ff;
   logic [VAL_W-1:0]     rd_thrust_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     rd_addr;

   mtp_div_ctl_type      div_ctl;
   mtp_div_rsp_type      div_rsp;

   logic                 req_acc;
   logic [CNT_W-1:0]     n_used;
   logic                 n_zero;
   logic                 slot_ok;
   logic [IDX_W-1:0]     last_addr;
   logic                 last_pt;
   logic                 found;
   logic                 early_out;
   logic [VAL_W-1:0]     mem_end;
   logic [VAL_W-1:0]     tick_end;
   logic [VAL_W:0]       tick_sum;

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign n_used    = (32'(point_count_ff) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : CNT_W'(point_count_ff);
   assign n_zero    = (n_used == '0);
   assign slot_ok   = (32'(pidx_ff) < 32'(MAX_POINTS));
   assign last_addr = IDX_W'(n_used - 1'b1);
   assign last_pt   = ((32'(idx_ff) + 1) == 32'(n_used));
   assign found     = (rd_time_ff >= burn_time_ff);
   assign mem_end   = n_zero ? '0 : rd_time_ff;
   assign tick_end  = (motor_mode_ff == MODE_CONSTANT) ? burn_duration_ff : mem_end;
   assign tick_sum  = {1'b0, burn_time_ff} + (VAL_W+1)'(dt_ff);
   assign early_out = !burning_ff || (motor_mode_ff == MODE_CONSTANT) ||
                      (burn_time_ff > end_ff) || n_zero;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_acc) state_in = S_EXEC;
         S_EXEC:  state_in = S_ENDRD;
         S_ENDRD: state_in = S_TICK;
         S_TICK:  state_in = S_SEL;
         S_SEL:   state_in = early_out ? S_DONE : S_SRCH;
         S_SRCH:  state_in = S_CMP;
         S_CMP: begin
            priority if (found) state_in = S_PREP;
            else if (last_pt)   state_in = S_DONE;
            else                state_in = S_SRCH;
         end
         S_PREP:  state_in = (len_ff == '0) ? S_DONE : S_DIV;
         S_DIV:   if (div_rsp.done) state_in = S_DONE;
         S_DONE:  if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      burning_in   = burning_ff;
      burn_time_in = burn_time_ff;
      cmd_in       = cmd_ff;
      dt_in        = dt_ff;
      pidx_in      = pidx_ff;
      ptime_in     = ptime_ff;
      pthrust_in   = pthrust_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      s_time_in    = s_time_ff;
      s_thrust_in  = s_thrust_ff;
      e_thrust_in  = e_thrust_ff;
      elapsed_in   = elapsed_ff;
      len_in       = len_ff;
      mag_in       = mag_ff;
      up_in        = up_ff;
      thrust_in    = thrust_ff;
      mem_we       = 1'b0;
      rd_addr      = idx_ff;
      div_ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd_in     = req_ch.cmd;
               dt_in      = req_ch.delta_time;
               pidx_in    = req_ch.point_index;
               ptime_in   = req_ch.point_time;
               pthrust_in = req_ch.point_thrust;
            end
         end
         S_EXEC: begin
            mem_we = (cmd_ff == CMD_WRITE) && slot_ok;
            if (cmd_ff == CMD_RESTART) begin
               burning_in   = 1'b1;
               burn_time_in = '0;
            end
         end
         S_ENDRD: begin
            rd_addr = last_addr;
         end
         S_TICK: begin
            end_in = mem_end;
            // exhaustion test uses the burn time before this tick
            if ((cmd_ff == CMD_TICK) && burning_ff) begin
               if (burn_time_ff >= tick_end) burning_in = 1'b0;
               burn_time_in = tick_sum[VAL_W] ? '1 : tick_sum[VAL_W-1:0];
            end
         end
         S_SEL: begin
            thrust_in   = (burning_ff && (motor_mode_ff == MODE_CONSTANT)) ?
                          constant_thrust_ff : '0;
            idx_in      = '0;
            s_time_in   = '0;
            s_thrust_in = '0;
         end
         S_SRCH: begin
         end
         S_CMP: begin
            priority if (found) begin
               // out-of-order points clamp elapsed and length at zero
               elapsed_in  = (burn_time_ff > s_time_ff) ? burn_time_ff - s_time_ff : '0;
               len_in      = (rd_time_ff >= s_time_ff) ? rd_time_ff - s_time_ff : '0;
               up_in       = (rd_thrust_ff >= s_thrust_ff);
               mag_in      = (rd_thrust_ff >= s_thrust_ff) ? rd_thrust_ff - s_thrust_ff
                                                           : s_thrust_ff - rd_thrust_ff;
               e_thrust_in = rd_thrust_ff;
            end else if (last_pt) begin
               thrust_in = '0;
            end else begin
               s_time_in   = rd_time_ff;
               s_thrust_in = rd_thrust_ff;
               idx_in      = idx_ff + 1'b1;
            end
         end
         S_PREP: begin
            if (len_ff == '0) begin
               thrust_in = e_thrust_ff;
            end else begin
               div_ctl.start   = 1'b1;
               div_ctl.mul_a   = (elapsed_ff > len_ff) ? len_ff : elapsed_ff;
               div_ctl.mul_b   = mag_ff;
               div_ctl.divisor = len_ff;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               thrust_in = up_ff ? s_thrust_ff + div_rsp.quotient
                                 : s_thrust_ff - div_rsp.quotient;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         burning_ff   <= 1'b1;
         burn_time_ff <= '0;
      end else begin
         state_ff     <= state_in;
         burning_ff   <= burning_in;
         burn_time_ff <= burn_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_mode_ff      <= MODE_CONSTANT;
         burn_duration_ff   <= '0;
         constant_thrust_ff <= '0;
         point_count_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOTOR_MODE:      motor_mode_ff      <= csr_wdata[0];
            CSR_BURN_DURATION:   burn_duration_ff   <= csr_wdata[VAL_W-1:0];
            CSR_CONSTANT_THRUST: constant_thrust_ff <= csr_wdata[VAL_W-1:0];
            CSR_POINT_COUNT:     point_count_ff     <= csr_wdata[PCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      dt_ff       <= dt_in;
      pidx_ff     <= pidx_in;
      ptime_ff    <= ptime_in;
      pthrust_ff  <= pthrust_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      s_time_ff   <= s_time_in;
      s_thrust_ff <= s_thrust_in;
      e_thrust_ff <= e_thrust_in;
      elapsed_ff  <= elapsed_in;
      len_ff      <= len_in;
      mag_ff      <= mag_in;
      up_ff       <= up_in;
      thrust_ff   <= thrust_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bp_time_mem[IDX_W'(pidx_ff)]   <= ptime_ff;
         bp_thrust_mem[IDX_W'(pidx_ff)] <= pthrust_ff;
      end
      rd_time_ff   <= bp_time_mem[rd_addr];
      rd_thrust_ff <= bp_thrust_mem[rd_addr];
   end

   mtp_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .rsp   (div_rsp)
   );

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = (state_ff == S_DONE);
   assign rsp_ch.thrust_out   = thrust_ff;
   assign rsp_ch.is_burning   = burning_ff;
   assign rsp_ch.elapsed_burn = burn_time_ff;

endmodule

@@ hdl/mtp_muldiv.sv @@
// iterative multiply-then-divide unit: (a * b) / d, one 32x32 product then
// 32 restoring divide steps on a single subtractor; depends on mtp_pkg
module mtp_muldiv (
   input  logic                    clock,
   input  logic                    reset,
   input  mtp_pkg::mtp_div_ctl_type ctl,
   output mtp_pkg::mtp_div_rsp_type rsp
);
   import mtp_pkg::*;

   localparam int STEPS  = VAL_W;
   localparam int STEP_W = $clog2(STEPS);

   mtp_div_state_type state_ff, state_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [VAL_W-1:0]  b_ff, b_in;
   logic [VAL_W-1:0]  d_ff, d_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   logic [2*VAL_W-1:0] product;
   logic [VAL_W:0]     shifted;
   logic [VAL_W:0]     diff;

   assign product = a_ff * b_ff;
   assign shifted = {rem_ff, quo_ff[VAL_W-1]};
   assign diff    = shifted - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DV_IDLE: if (ctl.start) state_in = DV_MUL;
         DV_MUL:  state_in = DV_STEP;
         DV_STEP: if (cnt_ff == STEP_W'(STEPS - 1)) state_in = DV_DONE;
         DV_DONE: state_in = DV_IDLE;
         default: state_in = DV_IDLE;
      endcase
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      d_in   = d_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (ctl.start) begin
               a_in = ctl.mul_a;
               b_in = ctl.mul_b;
               d_in = ctl.divisor;
            end
         end
         DV_MUL: begin
            // high half is below the divisor, so the quotient fits 32 bits
            rem_in = product[2*VAL_W-1:VAL_W];
            quo_in = product[VAL_W-1:0];
            cnt_in = '0;
         end
         DV_STEP: begin
            if (!diff[VAL_W]) begin
               rem_in = diff[VAL_W-1:0];
               quo_in = {quo_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[VAL_W-1:0];
               quo_in = {quo_ff[VAL_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         DV_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = (state_ff == DV_DONE);
   assign rsp.quotient = quo_ff;

endmodule

@@ hdl/mtp_checker.sv @@
// port-level checks for motor_thrust_profile, bound to the top level
// depends on mtp_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [mtp_pkg::VAL_W-1:0] rsp_thrust_out,
   input logic                      rsp_is_burning
);
   import mtp_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // one request in flight: no new request while a response is pending
   `MTP_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   // the block goes busy right after taking a request
   `MTP_ASSERT_NXT(a_busy_after_req, clock, reset, req_acc, !req_ready && !rsp_valid)
   // an exhausted motor gives no thrust
   `MTP_ASSERT_IMP(a_exhausted_no_thrust, clock, reset, rsp_valid && !rsp_is_burning, rsp_thrust_out == '0)
   // stalled response holds
   `MTP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_thrust_out))

endmodule

bind motor_thrust_profile mtp_checker u_mtp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_thrust_out (rsp_ch.thrust_out),
   .rsp_is_burning (rsp_ch.is_burning)
);
